// File: rtl/core/fastload_two_wire_link_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-wire fast-load link
// Shared property templates, clocked on i_clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FASTLOAD_TWO_WIRE_LINK_MACROS_SVH
`define FASTLOAD_TWO_WIRE_LINK_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FLTW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FLTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fltw_pkg.sv
// ---------------------------------------------------------------------------
// fltw_pkg
// Types and constants shared by the fast-load link modules.
// ---------------------------------------------------------------------------
package fltw_pkg;

    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_LOADER_MODE = 2'd0;

    localparam logic [1:0] MODE_CLOCK_RX = 2'd1;
    localparam logic [1:0] MODE_ATN_RX   = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEND   = 1'b1;

    // last edge index of a pair frame: ATN mode (two bits per edge) / CLOCK mode (one bit per edge)
    localparam logic [3:0] ATN_EDGES_LAST = 4'd7;
    localparam logic [3:0] CLK_EDGES_LAST = 4'd15;

    typedef enum logic [2:0] {
        TX_IDLE       = 3'd0,
        TX_WAIT_FALL0 = 3'd1,
        TX_WAIT_RISE0 = 3'd2,
        TX_WAIT_FALL1 = 3'd3,
        TX_WAIT_RISE1 = 3'd4
    } t_tx_phase;

    typedef struct packed {
        logic       op;
        logic       atn_level;
        logic       clock_level;
        logic       data_level;
        logic [7:0] tx_byte;
    } t_req;

    typedef struct packed {
        logic       clock_drive;
        logic       data_drive;
        logic       pair_valid;
        logic [7:0] track;
        logic [7:0] sector;
        logic       send_busy;
        logic       send_done;
    } t_rsp;

    typedef struct packed {
        logic       mode_wr;
        logic [1:0] loader_mode;
    } t_cfg;

endpackage

// File: rtl/core/fltw_req_if.sv
// ---------------------------------------------------------------------------
// fltw_req_if
// Request channel: line sample or send request, valid/ready handshake.
// ---------------------------------------------------------------------------
interface fltw_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic       atn_level;
    logic       clock_level;
    logic       data_level;
    logic [7:0] tx_byte;

    modport source (
        output valid, op, atn_level, clock_level, data_level, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, op, atn_level, clock_level, data_level, tx_byte,
        output ready
    );
endinterface

// File: rtl/core/fltw_rsp_if.sv
// ---------------------------------------------------------------------------
// fltw_rsp_if
// Result channel: line drives, received pair and send status.
// ---------------------------------------------------------------------------
interface fltw_rsp_if;
    logic       valid;
    logic       ready;
    logic       clock_drive;
    logic       data_drive;
    logic       pair_valid;
    logic [7:0] track;
    logic [7:0] sector;
    logic       send_busy;
    logic       send_done;

    modport source (
        output valid, clock_drive, data_drive, pair_valid, track, sector,
               send_busy, send_done,
        input  ready
    );
    modport sink (
        input  valid, clock_drive, data_drive, pair_valid, track, sector,
               send_busy, send_done,
        output ready
    );
endinterface

// File: rtl/core/fastload_two_wire_link.sv
// ---------------------------------------------------------------------------
// fastload_two_wire_link
// Device side of a two-wire fast-load link with APB mode register.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one request per handshake: a settled ATN/CLOCK/DATA
//   sample (op 0) or a request to start sending tx_byte (op 1).
//   o_rsp carries one result per request: the CLOCK/DATA drive levels,
//   the last received track/sector pair with a completion flag, and the
//   send busy/done flags.
//   loader_mode sits at APB byte address 0; write it only while idle.
// Result: a result is registered into the buffer as its request is taken, behind older results.
// Throughput: one request per cycle while i_req.ready is high; the edge detect,
//   shift and send sequencer update close before the result is registered.
// Stall: a two-entry result buffer absorbs a stalled receiver; i_req.ready
//   drops only while both entries are held.
// Reset: lines released, edge history high, no frame or send in progress,
//   pair zero, mode 0; the buffer empties.
// ---------------------------------------------------------------------------
`include "fastload_two_wire_link_macros.svh"

module fastload_two_wire_link
    import fltw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fltw_req_if.sink              i_req,
    fltw_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;
    t_req req;
    t_rsp core_rsp;
    t_rsp buf_rsp;
    logic accept;
    logic not_full;
    logic out_valid;

    assign req.op          = i_req.op;
    assign req.atn_level   = i_req.atn_level;
    assign req.clock_level = i_req.clock_level;
    assign req.data_level  = i_req.data_level;
    assign req.tx_byte     = i_req.tx_byte;

    assign i_req.ready = not_full;
    assign accept      = i_req.valid && not_full;

    fltw_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fltw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .i_cfg    (cfg),
        .o_rsp    (core_rsp)
    );

    fltw_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_rsp      (core_rsp),
        .o_not_full (not_full),
        .o_valid    (out_valid),
        .i_pop      (o_rsp.ready),
        .o_rsp      (buf_rsp)
    );

    assign o_rsp.valid       = out_valid;
    assign o_rsp.clock_drive = buf_rsp.clock_drive;
    assign o_rsp.data_drive  = buf_rsp.data_drive;
    assign o_rsp.pair_valid  = buf_rsp.pair_valid;
    assign o_rsp.track       = buf_rsp.track;
    assign o_rsp.sector      = buf_rsp.sector;
    assign o_rsp.send_busy   = buf_rsp.send_busy;
    assign o_rsp.send_done   = buf_rsp.send_done;

    // a taken request always leaves a result behind
    `FLTW_ASSERT_NEXT(a_req_gives_rsp, accept, o_rsp.valid, "request produced no result")
    // a pair never completes while a send is in progress on the ATN line
    `FLTW_ASSERT_SAME(a_pair_not_busy, o_rsp.valid && o_rsp.pair_valid, !o_rsp.send_busy, "pair during send")
    // a finished send leaves the sequencer idle
    `FLTW_ASSERT_SAME(a_done_idle, o_rsp.valid && o_rsp.send_done, !o_rsp.send_busy, "send done but busy")
    // ready drops only with results waiting
    `FLTW_ASSERT_SAME(a_stall_has_rsp, !i_req.ready, o_rsp.valid, "stall with empty buffer")

endmodule

// File: rtl/core/fltw_apb_regs.sv
// ---------------------------------------------------------------------------
// fltw_apb_regs
// APB register file holding loader_mode; flags every mode write.
// ---------------------------------------------------------------------------
module fltw_apb_regs
    import fltw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [1:0] r_mode;
    logic       wr_mode;

    assign pready  = 1'b1;
    assign wr_mode = psel && penable && pwrite && (paddr == REG_LOADER_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (wr_mode) begin
            r_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_LOADER_MODE) begin
            prdata = {{(APB_DATA_W-2){1'b0}}, r_mode};
        end
    end

    assign o_cfg.mode_wr     = wr_mode;
    assign o_cfg.loader_mode = r_mode;

endmodule

// File: rtl/core/fltw_core.sv
// ---------------------------------------------------------------------------
// fltw_core
// Link state: edge history, receive shifter, send sequencer, line drives.
// ---------------------------------------------------------------------------
module fltw_core
    import fltw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    logic        r_last_atn, n_last_atn;
    logic        r_last_clock, n_last_clock;
    logic [15:0] r_rx_shift, n_rx_shift;
    logic [3:0]  r_rx_count, n_rx_count;
    logic        r_rx_active, n_rx_active;
    logic [7:0]  r_tx_shift, n_tx_shift;
    t_tx_phase   r_tx_phase, n_tx_phase;
    logic [1:0]  r_drive, n_drive;
    logic [15:0] r_pair, n_pair;

    logic       pair_valid;
    logic       send_done;
    logic       atn_fall, atn_rise, clk_fall, clk_edge;
    logic       nc, nd;
    logic [3:0] top;
    logic [3:0] hi_pos, lo_pos;
    logic [7:0] tx_next;

    // a fresh frame restarts the count at zero
    function automatic logic [1:0] rx_nibble(logic [3:0] cnt, logic act);
        rx_nibble = act ? cnt[2:1] : 2'd0;
    endfunction

    function automatic logic rx_half(logic [3:0] cnt, logic act);
        rx_half = act ? cnt[0] : 1'b0;
    endfunction

    assign atn_fall = r_last_atn && !i_req.atn_level;
    assign atn_rise = !r_last_atn && i_req.atn_level;
    assign clk_fall = r_last_clock && !i_req.clock_level;
    assign clk_edge = r_last_clock != i_req.clock_level;
    assign nc       = ~i_req.clock_level;
    assign nd       = ~i_req.data_level;
    assign tx_next  = {4'd0, r_tx_shift[7:4]};

    // nibble slot: fall puts bits 3/1, rise bits 2/0 of the current nibble
    assign top    = 4'd15 - {rx_nibble(r_rx_count, r_rx_active), 2'b00};
    assign hi_pos = rx_half(r_rx_count, r_rx_active) ? top - 4'd1 : top;
    assign lo_pos = hi_pos - 4'd2;

    always_comb begin
        n_last_atn   = r_last_atn;
        n_last_clock = r_last_clock;
        n_rx_shift   = r_rx_shift;
        n_rx_count   = r_rx_count;
        n_rx_active  = r_rx_active;
        n_tx_shift   = r_tx_shift;
        n_tx_phase   = r_tx_phase;
        n_drive      = r_drive;
        n_pair       = r_pair;
        pair_valid   = 1'b0;
        send_done    = 1'b0;

        if (i_req.op == OP_SEND) begin
            n_tx_shift = i_req.tx_byte;
            n_drive    = i_req.tx_byte[1:0];
            n_tx_phase = TX_WAIT_FALL0;
        end else begin
            if (r_tx_phase != TX_IDLE) begin
                // send in progress owns the ATN line
                unique case (r_tx_phase)
                    TX_WAIT_FALL0, TX_WAIT_FALL1: begin
                        if (atn_fall) begin
                            n_drive    = r_tx_shift[3:2];
                            n_tx_phase = (r_tx_phase == TX_WAIT_FALL0) ? TX_WAIT_RISE0
                                                                        : TX_WAIT_RISE1;
                        end
                    end
                    TX_WAIT_RISE0: begin
                        if (atn_rise) begin
                            n_tx_shift = tx_next;
                            n_drive    = tx_next[1:0];
                            n_tx_phase = TX_WAIT_FALL1;
                        end
                    end
                    TX_WAIT_RISE1: begin
                        if (atn_rise) begin
                            n_tx_shift = tx_next;
                            n_tx_phase = TX_IDLE;
                            send_done  = 1'b1;
                        end
                    end
                    default: n_tx_phase = TX_IDLE;
                endcase
            end else if (i_cfg.loader_mode == MODE_ATN_RX) begin
                if (!r_rx_active && atn_fall) begin
                    n_rx_active = 1'b1;
                    n_rx_count  = '0;
                    n_rx_shift  = '0;
                end
                if (n_rx_active && (atn_fall || atn_rise)) begin
                    n_rx_shift = n_rx_shift | (16'(nc) << hi_pos) | (16'(nd) << lo_pos);
                    if (n_rx_count == ATN_EDGES_LAST) begin
                        n_pair      = n_rx_shift;
                        pair_valid  = 1'b1;
                        n_rx_active = 1'b0;
                        n_rx_count  = '0;
                    end else begin
                        n_rx_count = n_rx_count + 4'd1;
                    end
                end
            end else begin
                if (atn_fall) begin
                    n_drive[1] = 1'b0;
                end
                if (i_cfg.loader_mode == MODE_CLOCK_RX) begin
                    if (!r_rx_active && clk_fall) begin
                        n_rx_active = 1'b1;
                        n_rx_count  = '0;
                        n_rx_shift  = '0;
                    end
                    if (n_rx_active && clk_edge) begin
                        n_rx_shift = {n_rx_shift[14:0], nd};
                        if (n_rx_count == CLK_EDGES_LAST) begin
                            n_pair      = n_rx_shift;
                            pair_valid  = 1'b1;
                            n_rx_active = 1'b0;
                            n_rx_count  = '0;
                        end else begin
                            n_rx_count = n_rx_count + 4'd1;
                        end
                    end
                end
            end
            n_last_atn   = i_req.atn_level;
            n_last_clock = i_req.clock_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_atn   <= 1'b1;
            r_last_clock <= 1'b1;
            r_rx_shift   <= '0;
            r_rx_count   <= '0;
            r_rx_active  <= 1'b0;
            r_tx_shift   <= '0;
            r_tx_phase   <= TX_IDLE;
            r_drive      <= 2'b11;
            r_pair       <= '0;
        end else if (i_accept) begin
            r_last_atn   <= n_last_atn;
            r_last_clock <= n_last_clock;
            r_rx_shift   <= n_rx_shift;
            r_rx_count   <= n_rx_count;
            r_rx_active  <= n_rx_active;
            r_tx_shift   <= n_tx_shift;
            r_tx_phase   <= n_tx_phase;
            r_drive      <= n_drive;
            r_pair       <= n_pair;
        end else if (i_cfg.mode_wr) begin
            // mode change drops any frame in flight, unless a request is taken in the same cycle
            r_rx_active <= 1'b0;
            r_rx_count  <= '0;
        end
    end

    assign o_rsp.clock_drive = n_drive[0];
    assign o_rsp.data_drive  = n_drive[1];
    assign o_rsp.pair_valid  = pair_valid;
    assign o_rsp.track       = n_pair[15:8];
    assign o_rsp.sector      = n_pair[7:0];
    assign o_rsp.send_busy   = n_tx_phase != TX_IDLE;
    assign o_rsp.send_done   = send_done;

endmodule

// File: rtl/core/fltw_out_buf.sv
// ---------------------------------------------------------------------------
// fltw_out_buf
// Two-entry result buffer between the link state and the result channel.
// ---------------------------------------------------------------------------
module fltw_out_buf
    import fltw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rsp i_rsp,
    output logic o_not_full,
    output logic o_valid,
    input  logic i_pop,
    output t_rsp o_rsp
);

    t_rsp       r_slot [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic       pop_ok;

    assign o_not_full = r_cnt != 2'd2;
    assign o_valid    = r_cnt != 2'd0;
    assign o_rsp      = r_slot[r_rd_ptr];
    assign pop_ok     = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rsp;
        end
    end

endmodule
